>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define AED_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define AED_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent holds at the following edge.
`define AED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/aed_pkg.sv
// ---------------------------------------------------------------------------
// Envelope decimator package
// Sizes, register and format codes, controller states and divider structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package aed_pkg;

  localparam int unsigned MAX_CHANNELS   = 8;
  localparam int unsigned MAX_WINDOW     = 16;
  localparam int unsigned MAX_DECIMATION = 4095;

  // +1.5 in Q.23.
  localparam int unsigned FULL_SCALE = 12582912;

  localparam int unsigned SAMPLE_W  = 25;
  localparam int unsigned MEAN_W    = 24;
  localparam int unsigned CHAN_SUM_W = SAMPLE_W + $clog2(MAX_CHANNELS);
  localparam int unsigned CHAN_CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned WIN_PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned WIN_CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WIN_SUM_W  = MEAN_W + $clog2(MAX_WINDOW);
  localparam int unsigned DEC_W      = $clog2(MAX_DECIMATION + 1);
  localparam int unsigned BLOCK_SUM_W =
      $clog2(64'(MAX_DECIMATION) * 64'(FULL_SCALE) + 64'd1);

  localparam int unsigned NUM_W_A   = (BLOCK_SUM_W > WIN_SUM_W) ? BLOCK_SUM_W : WIN_SUM_W;
  localparam int unsigned DIV_NUM_W = (NUM_W_A > CHAN_SUM_W) ? NUM_W_A : CHAN_SUM_W;
  localparam int unsigned DEN_W_A   = (DEC_W > CHAN_CNT_W) ? DEC_W : CHAN_CNT_W;
  localparam int unsigned DIV_DEN_W = (DEN_W_A > WIN_CNT_W) ? DEN_W_A : WIN_CNT_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WINDOW = 2'd3;

  // Sample format codes.
  localparam logic [1:0] FMT_PCM16   = 2'd0;
  localparam logic [1:0] FMT_PCM24   = 2'd1;
  localparam logic [1:0] FMT_FLOAT32 = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_FRAME,
    ST_DIV_FRAME,
    ST_BLOCK,
    ST_DIV_MEAN,
    ST_WIN_READ,
    ST_WIN_SUB,
    ST_WIN_ADD,
    ST_SMOOTH,
    ST_DIV_SMOOTH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> hw/rtl/aed_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aed_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic                                          rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/aed_decoder.sv
// ---------------------------------------------------------------------------
// Sample decoder
// Turns a raw PCM16, PCM24 or float32 word into signed Q.23.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aed_decoder (
  input  logic [1:0]                           sample_format,
  input  logic [31:0]                          sample_word,
  output logic signed [aed_pkg::SAMPLE_W-1:0]  decoded
);

  import aed_pkg::*;

  logic        fp_sign;
  logic [7:0]  fp_exp;
  logic [22:0] fp_man;
  logic [7:0]  fp_shift;
  logic [23:0] fp_shifted;
  logic [MEAN_W-1:0] fp_mag;
  logic [SAMPLE_W-1:0] fp_mag_ext;
  logic signed [SAMPLE_W-1:0] fp_value;

  assign fp_sign    = sample_word[31];
  assign fp_exp     = sample_word[30:23];
  assign fp_man     = sample_word[22:0];
  assign fp_shift   = 8'd127 - fp_exp;
  assign fp_shifted = {1'b1, fp_man} >> fp_shift[4:0];

  always_comb begin
    priority if (fp_exp == 8'hFF) begin
      // A NaN decodes as zero, infinity clamps.
      fp_mag = (fp_man != 23'd0) ? '0 : MEAN_W'(FULL_SCALE);
    end else if (fp_exp == 8'd0) begin
      fp_mag = '0;
    end else if (fp_exp >= 8'd128) begin
      fp_mag = MEAN_W'(FULL_SCALE);
    end else if (fp_shift >= 8'd24) begin
      fp_mag = '0;
    end else if (fp_shifted > MEAN_W'(FULL_SCALE)) begin
      fp_mag = MEAN_W'(FULL_SCALE);
    end else begin
      fp_mag = fp_shifted;
    end
  end

  assign fp_mag_ext = {1'b0, fp_mag};
  assign fp_value   = fp_sign ? -$signed(fp_mag_ext) : $signed(fp_mag_ext);

  always_comb begin
    unique case (sample_format)
      FMT_PCM16:   decoded = $signed({sample_word[15], sample_word[15:0], 8'd0});
      FMT_PCM24:   decoded = $signed({sample_word[23], sample_word[23:0]});
      FMT_FLOAT32: decoded = fp_value;
      default:     decoded = '0;
    endcase
  end

endmodule

>>> hw/rtl/aed_divider.sv
// ---------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle, shared by all
// three divisions of the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aed_divider (
  input  logic               clk,
  input  logic               rst,
  input  aed_pkg::div_req_t  req,
  output aed_pkg::div_rsp_t  rsp
);

  import aed_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_NUM_W-1:0] quo_next;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] rem_next;
  logic [DIV_DEN_W-1:0] den_reg;
  logic [DIV_DEN_W:0]   rem_shift;
  logic [DIV_DEN_W:0]   rem_diff;
  logic                 fits;

  assign rem_shift = {rem, quo[DIV_NUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, den_reg};
  assign fits      = (rem_shift >= {1'b0, den_reg});
  assign rem_next  = fits ? rem_diff[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
  assign quo_next  = {quo[DIV_NUM_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The numerator shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.num;
      rem     <= '0;
      den_reg <= req.den;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

>>> hw/rtl/audio_envelope_decimator_core.sv
// ---------------------------------------------------------------------------
// Audio envelope decimator
// Samples arrive interleaved, one channel per input transfer (in_valid,
// in_stall, sample_word, restart). Each is decoded to Q.23 and summed over
// a frame; the frame magnitude is the truncated channel mean. After every
// decimation frames one result transfer (out_valid, out_stall) carries the
// block mean and a moving average over the last smooth_window block means.
// A sample that does not close a frame is only accumulated. Closing a frame
// adds the division by the channel count; closing a block adds two more
// divisions, for the block mean and the smoothed envelope, and the window
// update. All three divisions go through the one iterative divider.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are taken
// in any cycle outside reset; writing smooth_window empties the window.
// Reset restores the register defaults and clears all sums; the window
// memory needs no clearing pass. A result that the receiver stalls stays in
// the output register; the next sample is still taken, and the block only
// waits if a further result is ready before the first has been transferred.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module audio_envelope_decimator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [31:0]                     sample_word,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [aed_pkg::MEAN_W-1:0]      smoothed_envelope,
  output logic [aed_pkg::MEAN_W-1:0]      block_mean,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [aed_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aed_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import aed_pkg::*;

  state_t state;
  state_t state_next;

  logic [1:0]  sample_format;
  logic [3:0]  channel_count;
  logic [11:0] decimation;
  logic [4:0]  smooth_window;

  logic [CHAN_CNT_W-1:0] chans_eff;
  logic [DEC_W-1:0]      dec_eff;
  logic [WIN_CNT_W-1:0]  win_eff;

  logic [31:0] sample_reg;
  logic        restart_reg;
  logic signed [SAMPLE_W-1:0] decoded;

  logic signed [CHAN_SUM_W-1:0] channel_sum;
  logic [CHAN_CNT_W-1:0]        channel_index;
  logic [BLOCK_SUM_W-1:0]       block_sum;
  logic [DEC_W-1:0]             block_frames;
  logic [WIN_SUM_W-1:0]         window_sum;
  logic [WIN_PTR_W-1:0]         window_pointer;
  logic [WIN_CNT_W-1:0]         values_seen;
  logic [MEAN_W-1:0]            mean;

  logic signed [CHAN_SUM_W-1:0] base_sum;
  logic signed [CHAN_SUM_W-1:0] sum_new;
  logic [CHAN_CNT_W-1:0]        base_index;
  logic [CHAN_CNT_W-1:0]        index_new;
  logic                         frame_done;
  logic [CHAN_SUM_W-1:0]        chan_abs;
  logic                         window_full;
  logic [WIN_CNT_W-1:0]         pointer_inc;

  logic in_accept;
  logic cfg_write;
  logic out_load;
  logic ram_rd_en;
  logic ram_wr_en;
  logic [MEAN_W-1:0] ram_rd_data;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Register values outside their ranges act as the nearest legal value.
  always_comb begin
    if (channel_count == 4'd0) begin
      chans_eff = CHAN_CNT_W'(1);
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      chans_eff = CHAN_CNT_W'(MAX_CHANNELS);
    end else begin
      chans_eff = CHAN_CNT_W'(channel_count);
    end
    if (decimation == 12'd0) begin
      dec_eff = DEC_W'(1);
    end else if (32'(decimation) > MAX_DECIMATION) begin
      dec_eff = DEC_W'(MAX_DECIMATION);
    end else begin
      dec_eff = DEC_W'(decimation);
    end
    if (smooth_window == 5'd0) begin
      win_eff = WIN_CNT_W'(1);
    end else if (32'(smooth_window) > MAX_WINDOW) begin
      win_eff = WIN_CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = WIN_CNT_W'(smooth_window);
    end
  end

  aed_decoder u_decoder (
    .sample_format (sample_format),
    .sample_word   (sample_reg),
    .decoded       (decoded)
  );

  aed_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  aed_ram #(
    .WIDTH (MEAN_W),
    .DEPTH (MAX_WINDOW)
  ) u_window_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (window_pointer),
    .wr_data (mean),
    .rd_en   (ram_rd_en),
    .rd_addr (window_pointer),
    .rd_data (ram_rd_data)
  );

  // A restart sample starts a fresh frame on empty sums.
  assign base_sum    = restart_reg ? '0 : channel_sum;
  assign base_index  = restart_reg ? '0 : channel_index;
  assign sum_new     = base_sum + {{(CHAN_SUM_W - SAMPLE_W){decoded[SAMPLE_W-1]}}, decoded};
  assign index_new   = base_index + 1'b1;
  assign frame_done  = (index_new >= chans_eff);
  assign chan_abs    = channel_sum[CHAN_SUM_W-1] ? CHAN_SUM_W'(-channel_sum)
                                                 : CHAN_SUM_W'(channel_sum);
  assign window_full = (values_seen >= win_eff);
  assign pointer_inc = WIN_CNT_W'(window_pointer) + 1'b1;

  assign in_accept = in_valid && !in_stall;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (in_accept) state_next = ST_ACCUM;
      ST_ACCUM:      state_next = frame_done ? ST_FRAME : ST_IDLE;
      ST_FRAME:      state_next = ST_DIV_FRAME;
      ST_DIV_FRAME:  if (div_rsp.done) state_next = ST_BLOCK;
      ST_BLOCK:      state_next = (block_frames >= dec_eff) ? ST_DIV_MEAN : ST_IDLE;
      ST_DIV_MEAN:   if (div_rsp.done) state_next = ST_WIN_READ;
      ST_WIN_READ:   state_next = ST_WIN_SUB;
      ST_WIN_SUB:    state_next = ST_WIN_ADD;
      ST_WIN_ADD:    state_next = ST_SMOOTH;
      ST_SMOOTH:     state_next = ST_DIV_SMOOTH;
      ST_DIV_SMOOTH: if (div_rsp.done) state_next = ST_EMIT;
      ST_EMIT:       if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = rst || (state != ST_IDLE);
    cfg_ready   = !rst;
    div_req     = '0;
    ram_rd_en   = 1'b0;
    ram_wr_en   = 1'b0;
    out_load    = 1'b0;
    unique case (state)
      ST_FRAME: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(chan_abs);
        div_req.den   = DIV_DEN_W'(chans_eff);
      end
      ST_BLOCK: begin
        div_req.start = (block_frames >= dec_eff);
        div_req.num   = DIV_NUM_W'(block_sum);
        div_req.den   = DIV_DEN_W'(dec_eff);
      end
      ST_WIN_READ: ram_rd_en = 1'b1;
      ST_WIN_SUB:  ram_wr_en = 1'b1;
      ST_SMOOTH: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(window_sum);
        div_req.den   = DIV_DEN_W'(values_seen);
      end
      ST_EMIT: out_load = !out_valid || !out_stall;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_reg  <= sample_word;
      restart_reg <= restart;
    end
    if (out_load) begin
      smoothed_envelope <= div_rsp.quotient[MEAN_W-1:0];
      block_mean        <= mean;
    end
    if (state == ST_DIV_MEAN && div_rsp.done) begin
      mean <= (div_rsp.quotient > DIV_NUM_W'(FULL_SCALE)) ? MEAN_W'(FULL_SCALE)
                                                         : div_rsp.quotient[MEAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      sample_format  <= 2'd0;
      channel_count  <= 4'd2;
      decimation     <= 12'd220;
      smooth_window  <= 5'd10;
      channel_sum    <= '0;
      channel_index  <= '0;
      block_sum      <= '0;
      block_frames   <= '0;
      window_sum     <= '0;
      window_pointer <= '0;
      values_seen    <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        unique case (cfg_index)
          REG_SAMPLE_FORMAT: sample_format <= cfg_data[1:0];
          REG_CHANNEL_COUNT: channel_count <= cfg_data[3:0];
          REG_DECIMATION:    decimation    <= cfg_data[11:0];
          REG_SMOOTH_WINDOW: begin
            smooth_window  <= cfg_data[4:0];
            window_sum     <= '0;
            window_pointer <= '0;
            values_seen    <= '0;
          end
          default: begin
          end
        endcase
      end

      unique case (state)
        ST_ACCUM: begin
          channel_sum   <= sum_new;
          channel_index <= index_new;
          if (restart_reg) begin
            block_sum      <= '0;
            block_frames   <= '0;
            window_sum     <= '0;
            window_pointer <= '0;
            values_seen    <= '0;
          end
        end
        ST_FRAME: begin
          channel_sum   <= '0;
          channel_index <= '0;
        end
        ST_DIV_FRAME: begin
          // A frame closed early by a lowered channel count can exceed full scale.
          if (div_rsp.done) begin
            block_sum    <= block_sum + BLOCK_SUM_W'(div_rsp.quotient[CHAN_SUM_W-1:0]);
            block_frames <= block_frames + 1'b1;
          end
        end
        ST_BLOCK: begin
          if (block_frames >= dec_eff) begin
            block_sum    <= '0;
            block_frames <= '0;
          end
        end
        ST_DIV_MEAN: begin
          if (div_rsp.done && (WIN_CNT_W'(window_pointer) >= win_eff)) begin
            window_pointer <= '0;
          end
        end
        ST_WIN_SUB: begin
          // The oldest entry leaves once the window is full.
          if (window_full) begin
            window_sum <= window_sum - WIN_SUM_W'(ram_rd_data);
          end else begin
            values_seen <= values_seen + 1'b1;
          end
        end
        ST_WIN_ADD: begin
          window_sum <= window_sum + WIN_SUM_W'(mean);
          if (pointer_inc >= win_eff) begin
            window_pointer <= '0;
          end else begin
            window_pointer <= pointer_inc[WIN_PTR_W-1:0];
          end
        end
        default: begin
        end
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `AED_ASSERT_ALWAYS(a_seen_within_window, values_seen <= win_eff,
                     "window fill count exceeds the window length")
  `AED_ASSERT_IMPLIES(a_pointer_in_window, state == ST_IDLE,
                      WIN_CNT_W'(window_pointer) < win_eff,
                      "window pointer outside the window while idle")
  `AED_ASSERT_IMPLIES(a_div_done_when_waiting, div_rsp.done,
                      (state == ST_DIV_FRAME) || (state == ST_DIV_MEAN) ||
                      (state == ST_DIV_SMOOTH),
                      "divider finished while the controller was not waiting")

endmodule

>>> dv/envelope_checker.sv
// ---------------------------------------------------------------------------
// Envelope decimator checker
// Watches the configuration, sample and result channels of the envelope
// decimator. Keeps its own copy of the registers and accumulators, works out
// the block mean and smoothed envelope due when a sample closes a block, and
// compares each result transfer field by field with the oldest one due.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module envelope_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [31:0]                    sample_word,
  input  logic                           restart,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [aed_pkg::MEAN_W-1:0]     smoothed_envelope,
  input  logic [aed_pkg::MEAN_W-1:0]     block_mean,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [aed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aed_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             results_due
);

  import aed_pkg::*;

  typedef struct packed {
    logic [MEAN_W-1:0] smoothed;
    logic [MEAN_W-1:0] mean;
  } envelope_t;

  envelope_t envelope_due_q[$];

  logic [1:0]  fmt_cfg;
  logic [3:0]  chans_cfg;
  logic [11:0] dec_cfg;
  logic [4:0]  win_cfg;

  longint            chan_acc;
  int unsigned       chan_idx;
  longint unsigned   block_acc;
  int unsigned       block_cnt;
  logic [MEAN_W-1:0] window_mem [MAX_WINDOW];
  longint unsigned   win_acc;
  int unsigned       win_ptr;
  int unsigned       seen;

  function automatic void clear_window();
    win_acc = 0;
    win_ptr = 0;
    seen    = 0;
  endfunction

  function automatic void clear_all();
    chan_acc  = 0;
    chan_idx  = 0;
    block_acc = 0;
    block_cnt = 0;
    clear_window();
  endfunction

  // Signed Q.23 value of one raw sample under the current format.
  function automatic longint q23_of(logic [31:0] w);
    logic [7:0]      ex;
    int unsigned     shift;
    longint unsigned mag;
    case (fmt_cfg)
      FMT_PCM16:   return longint'(signed'(w[15:0])) * 256;
      FMT_PCM24:   return longint'(signed'(w[23:0]));
      FMT_FLOAT32: begin
        ex = w[30:23];
        if (ex == 8'hFF) begin
          // NaN reads as silence; infinity clamps like any large value.
          mag = (w[22:0] != 0) ? 0 : FULL_SCALE;
        end else if (ex == 8'h00) begin
          mag = 0;
        end else if (ex >= 8'd128) begin
          mag = FULL_SCALE;
        end else begin
          shift = 127 - ex;
          mag = (shift >= 24) ? 0 : ({1'b1, w[22:0]} >> shift);
          if (mag > FULL_SCALE) mag = FULL_SCALE;
        end
        return w[31] ? -longint'(mag) : longint'(mag);
      end
      default:     return 0;
    endcase
  endfunction

  task automatic predict_envelope(input logic [31:0] w, input logic clr);
    int unsigned     n_ch;
    int unsigned     n_dec;
    int unsigned     n_win;
    longint unsigned frame_mag;
    longint unsigned mean;
    longint unsigned fill;
    envelope_t       e;
    n_ch  = (chans_cfg == 0) ? 1 : ((chans_cfg > MAX_CHANNELS) ? MAX_CHANNELS : chans_cfg);
    n_dec = (dec_cfg == 0) ? 1 : dec_cfg;
    n_win = (win_cfg == 0) ? 1 : ((win_cfg > MAX_WINDOW) ? MAX_WINDOW : win_cfg);
    if (clr) clear_all();

    chan_acc += q23_of(w);
    chan_idx++;
    // A lowered channel count closes a part-filled frame at this sample.
    if (chan_idx < n_ch) return;
    frame_mag = (chan_acc < 0) ? -chan_acc : chan_acc;
    frame_mag = frame_mag / n_ch;
    chan_acc  = 0;
    chan_idx  = 0;

    block_acc += frame_mag;
    block_cnt++;
    if (block_cnt < n_dec) return;
    mean = block_acc / n_dec;
    if (mean > FULL_SCALE) mean = FULL_SCALE;
    block_acc = 0;
    block_cnt = 0;

    if (win_ptr >= n_win) win_ptr = 0;
    if (seen >= n_win) win_acc -= window_mem[win_ptr];
    else seen++;
    window_mem[win_ptr] = mean[MEAN_W-1:0];
    win_acc += mean;
    win_ptr++;
    if (win_ptr >= n_win) win_ptr = 0;

    fill = (seen != 0) ? seen : 1;
    e.smoothed = MEAN_W'(win_acc / fill);
    e.mean     = MEAN_W'(mean);
    envelope_due_q.insert(envelope_due_q.size(), e);
  endtask

  always @(posedge clk) begin
    envelope_t e;
    if (rst) begin
      fmt_cfg   = FMT_PCM16;
      chans_cfg = 4'd2;
      dec_cfg   = 12'd220;
      win_cfg   = 5'd10;
      clear_all();
      envelope_due_q.delete();
    end else begin
      // A result transfer at this edge stems from earlier samples, so it is
      // checked before the sample taken at the same edge is predicted.
      if (out_valid && !out_stall) begin
        if (envelope_due_q.size() == 0) begin
          $error("result with none due: smoothed_envelope %0d, block_mean %0d",
                 smoothed_envelope, block_mean);
          fail_count++;
        end else begin
          e = envelope_due_q.pop_front();
          if (smoothed_envelope !== e.smoothed) begin
            $error("smoothed_envelope: expected %0d, got %0d", e.smoothed, smoothed_envelope);
            fail_count++;
          end
          if (block_mean !== e.mean) begin
            $error("block_mean: expected %0d, got %0d", e.mean, block_mean);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLE_FORMAT: fmt_cfg   = cfg_data[1:0];
          REG_CHANNEL_COUNT: chans_cfg = cfg_data[3:0];
          REG_DECIMATION:    dec_cfg   = cfg_data[11:0];
          REG_SMOOTH_WINDOW: begin
            win_cfg = cfg_data[4:0];
            clear_window();
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_envelope(sample_word, restart);
    end
    results_due = envelope_due_q.size();
  end

endmodule

>>> dv/tb.sv
// ---------------------------------------------------------------------------
// Envelope decimator testbench
// Drives directed samples in every format, special float codes, register
// edge values and mid-frame or mid-block register changes, then random
// phases of random register settings and sample bursts. Both channels idle
// at random, and the receiver once holds off long enough to back the block
// up. The checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import aed_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam logic [1:0]  FMT_UNUSED   = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [31:0]           sample_word = '0;
  logic                  restart = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [MEAN_W-1:0]     smoothed_envelope;
  logic [MEAN_W-1:0]     block_mean;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int          fail_count;
  int          results_due;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;
  logic [1:0]  cur_fmt = FMT_PCM16;

  audio_envelope_decimator_core dut (
    .clk, .rst, .in_valid, .in_stall, .sample_word, .restart,
    .out_valid, .out_stall, .smoothed_envelope, .block_mean,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  envelope_checker checker_i (
    .clk, .rst, .in_valid, .in_stall, .sample_word, .restart,
    .out_valid, .out_stall, .smoothed_envelope, .block_mean,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .results_due
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_SAMPLE_FORMAT) cur_fmt = data[1:0];
  endtask

  task automatic configure(input logic [1:0] fmt, input int unsigned ch,
                           input int unsigned dec, input int unsigned win);
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(fmt));
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(ch));
    write_reg(REG_DECIMATION, CFG_DATA_W'(dec));
    write_reg(REG_SMOOTH_WINDOW, CFG_DATA_W'(win));
  endtask

  // Registers only change once every result has gone and the last sample
  // has had time to work its way through the frame and block arithmetic.
  task automatic settle();
    in_valid = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One sample transfer; between bursts the sender drops valid for a while.
  task automatic send(input logic [31:0] w, input logic clr);
    sample_word = w;
    restart     = clr;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
    end
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    if (cur_fmt == FMT_FLOAT32) begin
      // Mostly exponents around full scale, so that the values matter.
      case ($urandom_range(0, 9))
        0: ;
        1: begin
          w[30:23] = 8'hFF;
          if ($urandom_range(0, 1) == 0) w[22:0] = '0;
        end
        2: w[30:23] = 8'h00;
        default: w[30:23] = 8'($urandom_range(100, 130));
      endcase
    end
    return w;
  endfunction

  initial begin
    int unsigned random_sent;
    int unsigned n;
    random_sent = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // PCM16 extremes, garbage in the upper half, and a restart.
    configure(FMT_PCM16, 1, 1, 2);
    send(32'h0000_7FFF, 1'b0);
    send(32'hFFFF_8000, 1'b0);
    send(32'h0000_FFFF, 1'b0);
    send(32'hABCD_0000, 1'b0);
    send(32'h0000_1234, 1'b1);

    settle();
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_PCM24));
    send(32'h007F_FFFF, 1'b0);
    send(32'hFF80_0000, 1'b0);
    send(32'h12FF_FFFF, 1'b0);

    // Infinities, NaN, a denormal, clamping and the smallest nonzero step.
    settle();
    write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(FMT_FLOAT32));
    write_reg(REG_SMOOTH_WINDOW, CFG_DATA_W'(MAX_WINDOW));
    send(32'h7F80_0000, 1'b0);
    send(32'hFF80_0000, 1'b0);
    send(32'h7FC0_0001, 1'b0);
    send(32'h0000_0001, 1'b0);
    send(32'h3F80_0000, 1'b0);
    send(32'h4000_0000, 1'b0);
    send(32'hBFA0_0000, 1'b0);
    send(32'h3400_0000, 1'b0);
    send(32'h33FF_FFFF, 1'b0);

    // Unused format with zero channel count, decimation and window.
    settle();
    configure(FMT_UNUSED, 0, 0, 0);
    send(32'hFFFF_FFFF, 1'b0);

    // Decimation lowered part way through a block: the mean saturates.
    settle();
    configure(FMT_FLOAT32, 1, 5, 3);
    repeat (3) send(32'h3FC0_0000, 1'b0);
    settle();
    write_reg(REG_DECIMATION, CFG_DATA_W'(2));
    send(32'h3FC0_0000, 1'b0);

    // Channel count lowered part way through a frame.
    settle();
    configure(FMT_PCM16, 3, 1, 3);
    send(32'h0000_4000, 1'b0);
    send(32'h0000_C001, 1'b0);
    settle();
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(2));
    send(32'h0000_7FFF, 1'b0);

    // One result per sample while the receiver holds off, so the block backs up.
    settle();
    configure(FMT_PCM16, 1, 1, 4);
    hold_req = 1'b1;
    repeat (60) send(random_word(), 1'b0);
    random_sent += 60;

    // Largest settings, then the block is closed by dropping the decimation.
    settle();
    configure(FMT_FLOAT32, MAX_CHANNELS, MAX_DECIMATION, MAX_WINDOW);
    repeat (20) send(random_word(), 1'b0);
    settle();
    write_reg(REG_DECIMATION, CFG_DATA_W'(1));
    repeat (4) send(random_word(), 1'b0);
    random_sent += 24;

    while (random_sent < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 1) == 0)
        write_reg(REG_SAMPLE_FORMAT,
                  ($urandom_range(0, 9) == 0) ? CFG_DATA_W'(FMT_UNUSED)
                                              : CFG_DATA_W'($urandom_range(0, 2)));
      if ($urandom_range(0, 1) == 0)
        write_reg(REG_CHANNEL_COUNT,
                  ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 15))
                                              : CFG_DATA_W'($urandom_range(1, MAX_CHANNELS)));
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 19))
          0:       write_reg(REG_DECIMATION, CFG_DATA_W'(0));
          1:       write_reg(REG_DECIMATION, CFG_DATA_W'(MAX_DECIMATION));
          2:       write_reg(REG_DECIMATION, CFG_DATA_W'($urandom_range(0, MAX_DECIMATION)));
          3, 4, 5: write_reg(REG_DECIMATION, CFG_DATA_W'($urandom_range(5, 32)));
          default: write_reg(REG_DECIMATION, CFG_DATA_W'($urandom_range(1, 4)));
        endcase
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_SMOOTH_WINDOW,
                  ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 31))
                                              : CFG_DATA_W'($urandom_range(1, MAX_WINDOW)));
      n = $urandom_range(10, 80);
      repeat (n) send(random_word(), $urandom_range(0, 39) == 0);
      random_sent += n;
    end

    in_valid = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Receiver: stretches of free flow, sparse and heavy random stalls, and a
  // single long hold-off once the stimulus asks for it.
  initial begin
    int unsigned mode;
    int unsigned len;
    bit          hold_taken;
    hold_taken = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_taken = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(10, 120);
        repeat (len) begin
          case (mode)
            0:       out_stall = 1'b0;
            1:       out_stall = ($urandom_range(0, 1) == 0);
            2:       out_stall = ($urandom_range(0, 7) == 0);
            default: out_stall = ($urandom_range(0, 3) != 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

endmodule
